// ===== sv/sspq_pkg.sv =====
// Shared types and codes for the stable sorted priority queue.
// No dependencies; used by sspq_cell and stable_sorted_priority_queue.
package sspq_pkg;

  // Operation codes carried on the kind field
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;      // shift tail-ward from the insert point, load new entry
    logic rem;      // shift head-ward, dropping the head
    logic ordered;  // insert point found by key compare
  } cell_ctrl_t;

endpackage

// ===== sv/sspq_cell.sv =====
// One storage cell of the queue chain: a key and payload register plus the
// insert-point search link. Depends on sspq_pkg.
module sspq_cell #(
  parameter int KEY_BITS     = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                    clk,
  input  sspq_pkg::cell_ctrl_t    ctrl,
  input  logic                    occ,
  input  logic [KEY_BITS-1:0]     new_key,
  input  logic [PAYLOAD_BITS-1:0] new_payload,
  input  logic [KEY_BITS-1:0]     left_key,
  input  logic [PAYLOAD_BITS-1:0] left_payload,
  input  logic [KEY_BITS-1:0]     right_key,
  input  logic [PAYLOAD_BITS-1:0] right_payload,
  input  logic                    found_in,
  output logic                    found_out,
  output logic [KEY_BITS-1:0]     key,
  output logic [PAYLOAD_BITS-1:0] payload
);

  logic                    hit;
  logic [KEY_BITS-1:0]     key_next;
  logic [PAYLOAD_BITS-1:0] payload_next;

  // Insert point: first free cell, or (in ordered mode) first stored key above the new key
  assign hit       = !occ || (ctrl.ordered && (key > new_key));
  assign found_out = found_in || hit;

  // Select the next contents of this cell
  always_comb begin
    key_next     = key;
    payload_next = payload;
    if (ctrl.ins) begin
      if (found_in) begin
        key_next     = left_key;
        payload_next = left_payload;
      end else if (hit) begin
        key_next     = new_key;
        payload_next = new_payload;
      end
    end else if (ctrl.rem) begin
      key_next     = right_key;
      payload_next = right_payload;
    end
  end

  // Hold or advance the entry
  always_ff @(posedge clk) begin
    key     <= key_next;
    payload <= payload_next;
  end

endmodule

// ===== sv/stable_sorted_priority_queue.sv =====
// Stable sorted priority queue: a chain of DEPTH cells kept in queue order.
// The result beat is registered and appears in the cycle after start is taken.
// Throughput: one operation per cycle; busy is never raised, since every
// cell shifts or loads in the same cycle and the receiver cannot stall.
// Reset (rst, synchronous): entry count, ordered_mode and done clear to zero;
// cell contents are left as they are and are never read while unoccupied.
module stable_sorted_priority_queue #(
  parameter int DEPTH        = 64,
  parameter int KEY_BITS     = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              kind,
  input  logic [KEY_BITS-1:0]     item_key,
  input  logic [PAYLOAD_BITS-1:0] item_payload,
  input  logic                    cfg_we,
  input  logic                    cfg_wdata,
  output logic                    done,
  output logic [KEY_BITS-1:0]     out_key,
  output logic [PAYLOAD_BITS-1:0] out_payload,
  output logic [1:0]              status,
  output logic                    now_empty
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic                    ordered_mode;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic                    accept;
  logic                    full;
  logic                    empty;
  sspq_pkg::cell_ctrl_t    ctrl;
  sspq_pkg::status_t       status_next;
  logic                    take_head;

  logic [KEY_BITS-1:0]     cell_key [DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_pay [DEPTH];
  logic [DEPTH:0]          found;
  logic [DEPTH-1:0]        occ;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == FULL_CNT);
  assign empty  = (count == '0);

  // Decode the beat into a chain command, next count and status
  always_comb begin
    ctrl.ins     = 1'b0;
    ctrl.rem     = 1'b0;
    ctrl.ordered = ordered_mode;
    count_next   = count;
    status_next  = sspq_pkg::ST_OK;
    take_head    = 1'b0;
    if (accept) begin
      unique case (kind)
        sspq_pkg::KIND_INSERT: begin
          if (full) begin
            status_next = sspq_pkg::ST_FULL;
          end else begin
            ctrl.ins   = 1'b1;
            count_next = count + CNT_W'(1);
          end
        end
        sspq_pkg::KIND_REMOVE: begin
          if (empty) begin
            status_next = sspq_pkg::ST_EMPTY;
          end else begin
            ctrl.rem   = 1'b1;
            take_head  = 1'b1;
            count_next = count - CNT_W'(1);
          end
        end
        sspq_pkg::KIND_CLEAR: begin
          count_next = '0;
        end
        default: begin
          count_next = count;
        end
      endcase
    end
  end

  // Hold the mode register and the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      ordered_mode <= 1'b0;
      count        <= '0;
    end else begin
      if (cfg_we) begin
        ordered_mode <= cfg_wdata;
      end
      count <= count_next;
    end
  end

  // Register the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    out_key     <= take_head ? cell_key[0] : '0;
    out_payload <= take_head ? cell_pay[0] : '0;
    status      <= status_next;
    now_empty   <= (count_next == '0);
  end

  // Build the cell chain; the search link runs from head to tail
  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0]     lk;
    logic [PAYLOAD_BITS-1:0] lp;
    logic [KEY_BITS-1:0]     rk;
    logic [PAYLOAD_BITS-1:0] rp;

    assign occ[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign lk = item_key;
      assign lp = item_payload;
    end else begin : g_mid
      assign lk = cell_key[i-1];
      assign lp = cell_pay[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rk = cell_key[i];
      assign rp = cell_pay[i];
    end else begin : g_inner
      assign rk = cell_key[i+1];
      assign rp = cell_pay[i+1];
    end

    sspq_cell #(
      .KEY_BITS     (KEY_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .occ           (occ[i]),
      .new_key       (item_key),
      .new_payload   (item_payload),
      .left_key      (lk),
      .left_payload  (lp),
      .right_key     (rk),
      .right_payload (rp),
      .found_in      (found[i]),
      .found_out     (found[i+1]),
      .key           (cell_key[i]),
      .payload       (cell_pay[i])
    );
  end

  // Every accepted beat yields exactly one result beat next cycle
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("result beat missing after accepted command");

  // Entry count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count exceeds depth");

  // Empty flag on a result agrees with the stored count
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (now_empty == (count == '0)))
    else $error("now_empty disagrees with entry count");

  // A remove on an empty queue reports empty and leaves the count at zero
  a_remove_empty: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == sspq_pkg::KIND_REMOVE) && empty)
      |=> (status == sspq_pkg::ST_EMPTY) && (count == '0))
    else $error("remove on empty queue misreported");

  // A dropped insert leaves the store full
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == sspq_pkg::KIND_INSERT) && full)
      |=> (status == sspq_pkg::ST_FULL) && (count == FULL_CNT))
    else $error("insert on full queue misreported");

endmodule
